// ===== hw/rtl/fbpa_pkg.sv =====
// Package with shared types, codes and default sizes for the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  // Default pool geometry.
  localparam int unsigned DEF_SMALL_BLOCK = 16;
  localparam int unsigned DEF_SMALL_COUNT = 8;
  localparam int unsigned DEF_MID_BLOCK   = 32;
  localparam int unsigned DEF_MID_COUNT   = 8;
  localparam int unsigned DEF_LARGE_BLOCK = 64;
  localparam int unsigned DEF_LARGE_COUNT = 4;

  // Fixed layout facts.
  localparam int unsigned NUM_POOLS = 3;
  localparam int unsigned POOL_W    = 2;
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned SIZE_W    = 8;

  // Request kinds carried in the action field.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller state machine that sequences capture and execution of one request beat.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fbpa_pkg::dp_status_t dp_status,
  output fbpa_pkg::cmd_t      cmd,
  output logic                in_stall
);
  import fbpa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a beat when idle, execute once the result register can take it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!dp_status.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.execute = !dp_status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fbpa_dp.sv =====
// Datapath with the free lists, pool heads, address decode and result register.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_dp #(
  parameter int unsigned SMALL_BLOCK = fbpa_pkg::DEF_SMALL_BLOCK,
  parameter int unsigned SMALL_COUNT = fbpa_pkg::DEF_SMALL_COUNT,
  parameter int unsigned MID_BLOCK   = fbpa_pkg::DEF_MID_BLOCK,
  parameter int unsigned MID_COUNT   = fbpa_pkg::DEF_MID_COUNT,
  parameter int unsigned LARGE_BLOCK = fbpa_pkg::DEF_LARGE_BLOCK,
  parameter int unsigned LARGE_COUNT = fbpa_pkg::DEF_LARGE_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fbpa_pkg::cmd_t                        cmd,
  output fbpa_pkg::dp_status_t                  dp_status,
  input  logic                                  cfg_we,
  input  logic [fbpa_pkg::ADDR_W-1:0]           cfg_wdata,
  input  logic                                  in_action,
  input  logic [fbpa_pkg::SIZE_W-1:0]           in_req_size,
  input  logic [fbpa_pkg::ADDR_W-1:0]           in_release_addr,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]           out_block_addr
);
  import fbpa_pkg::*;

  localparam int unsigned TOTAL  = SMALL_COUNT + MID_COUNT + LARGE_COUNT;
  localparam int unsigned LINK_W = $clog2(TOTAL + 1);
  localparam int unsigned IDX_W  = $clog2(TOTAL);
  localparam int unsigned MAX_COUNT =
    (SMALL_COUNT > MID_COUNT) ?
      ((SMALL_COUNT > LARGE_COUNT) ? SMALL_COUNT : LARGE_COUNT) :
      ((MID_COUNT > LARGE_COUNT) ? MID_COUNT : LARGE_COUNT);
  localparam int unsigned K_W = $clog2(MAX_COUNT + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TOTAL);

  localparam int unsigned SIZE  [NUM_POOLS] = '{SMALL_BLOCK, MID_BLOCK, LARGE_BLOCK};
  localparam int unsigned COUNT [NUM_POOLS] = '{SMALL_COUNT, MID_COUNT, LARGE_COUNT};
  localparam int unsigned FIRST [NUM_POOLS] = '{0, SMALL_COUNT, SMALL_COUNT + MID_COUNT};
  localparam int unsigned OFFSET[NUM_POOLS] = '{0, SMALL_COUNT * SMALL_BLOCK,
                                                SMALL_COUNT * SMALL_BLOCK
                                                + MID_COUNT * MID_BLOCK};
  localparam int unsigned SPAN  [NUM_POOLS] = '{SMALL_COUNT * SMALL_BLOCK,
                                                MID_COUNT * MID_BLOCK,
                                                LARGE_COUNT * LARGE_BLOCK};

  // Configuration and captured request.
  logic [ADDR_W-1:0] area_base_r;
  logic              act_r;
  logic [SIZE_W-1:0] req_r;
  logic [ADDR_W-1:0] rel_r;

  // Free list state.
  logic [LINK_W-1:0] link_r [TOTAL];
  logic [LINK_W-1:0] head_r [NUM_POOLS];

  // Result register.
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  // Allocate decode.
  logic              a_hit;
  logic [POOL_W-1:0] a_pool;
  logic [LINK_W-1:0] a_head;
  logic [IDX_W-1:0]  a_idx;
  logic              a_empty;
  logic [LINK_W-1:0] a_k_full;
  logic [K_W-1:0]    a_k;
  logic [ADDR_W-1:0] a_addr;

  // Free decode.
  logic [ADDR_W-1:0] f_off;
  logic              f_hit;
  logic [POOL_W-1:0] f_pool;
  logic [ADDR_W-1:0] f_roff;
  logic              f_ok;
  logic [IDX_W-1:0]  f_idx;

  assign dp_status.out_busy = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_block_addr     = out_addr_r;

  // Pick the first pool whose payload fits, then form the granted address.
  always_comb begin
    a_hit  = 1'b0;
    a_pool = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!a_hit && (32'(req_r) <= SIZE[p] - HDR_BYTES)) begin
        a_hit  = 1'b1;
        a_pool = POOL_W'(p);
      end
    end
    a_head   = head_r[a_pool];
    a_idx    = a_head[IDX_W-1:0];
    a_empty  = (a_head == NULL_LINK);
    a_k_full = a_head - LINK_W'(FIRST[a_pool]);
    a_k      = a_k_full[K_W-1:0];
    a_addr   = area_base_r + ADDR_W'(OFFSET[a_pool])
             + ADDR_W'(32'(a_k) * SIZE[a_pool]) + ADDR_W'(HDR_BYTES);
  end

  // Locate the pool that holds the freed address and match a block start.
  always_comb begin
    f_off  = rel_r - area_base_r - ADDR_W'(HDR_BYTES);
    f_hit  = 1'b0;
    f_pool = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!f_hit && (f_off >= ADDR_W'(OFFSET[p]))
          && ((f_off - ADDR_W'(OFFSET[p])) < ADDR_W'(SPAN[p]))) begin
        f_hit  = 1'b1;
        f_pool = POOL_W'(p);
      end
    end
    f_roff = f_off - ADDR_W'(OFFSET[f_pool]);
    f_ok   = 1'b0;
    f_idx  = '0;
    for (int j = 0; j < MAX_COUNT; j++) begin
      if (f_hit && (j < COUNT[f_pool]) && (f_roff == ADDR_W'(j * SIZE[f_pool]))) begin
        f_ok  = 1'b1;
        f_idx = IDX_W'(FIRST[f_pool] + j);
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_base_r <= '0;
    end else if (cfg_we) begin
      area_base_r <= cfg_wdata;
    end
  end

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      req_r <= in_req_size;
      rel_r <= in_release_addr;
    end
  end

  // Free lists: rebuilt as ascending chains on reset, updated on execute.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL; i++) begin
        if ((i == FIRST[1] - 1) || (i == FIRST[2] - 1) || (i == TOTAL - 1)) begin
          link_r[i] <= NULL_LINK;
        end else begin
          link_r[i] <= LINK_W'(i + 1);
        end
      end
      for (int p = 0; p < NUM_POOLS; p++) begin
        head_r[p] <= LINK_W'(FIRST[p]);
      end
    end else if (cmd.execute) begin
      if (act_r == ACT_ALLOC) begin
        if (a_hit && !a_empty) begin
          head_r[a_pool] <= link_r[a_idx];
          link_r[a_idx]  <= NULL_LINK;
        end
      end else if (f_ok) begin
        link_r[f_idx]  <= head_r[f_pool];
        head_r[f_pool] <= LINK_W'(f_idx);
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (act_r == ACT_ALLOC) begin
        if (!a_hit) begin
          out_status_r <= ST_TOO_LARGE;
          out_addr_r   <= '0;
        end else if (a_empty) begin
          out_status_r <= ST_EMPTY;
          out_addr_r   <= '0;
        end else begin
          out_status_r <= ST_OK;
          out_addr_r   <= a_addr;
        end
      end else begin
        out_status_r <= f_ok ? ST_OK : ST_BAD_FREE;
        out_addr_r   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: controller plus datapath.
// Sequence: a request beat is captured in the idle state, then executed in the exec state
// once the result register can take it; the result is registered and presented.
// A new request is taken only after the current one executes, as set by the capture
// then execute sequence around one read-modify-write of a pool head and its link entry.
// Reset (synchronous, active low) rebuilds every free list and clears the area base
// to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int unsigned SMALL_BLOCK = fbpa_pkg::DEF_SMALL_BLOCK,
  parameter int unsigned SMALL_COUNT = fbpa_pkg::DEF_SMALL_COUNT,
  parameter int unsigned MID_BLOCK   = fbpa_pkg::DEF_MID_BLOCK,
  parameter int unsigned MID_COUNT   = fbpa_pkg::DEF_MID_COUNT,
  parameter int unsigned LARGE_BLOCK = fbpa_pkg::DEF_LARGE_BLOCK,
  parameter int unsigned LARGE_COUNT = fbpa_pkg::DEF_LARGE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fbpa_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [fbpa_pkg::SIZE_W-1:0] in_req_size,
  input  logic [fbpa_pkg::ADDR_W-1:0] in_release_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [fbpa_pkg::ADDR_W-1:0] out_block_addr
);
  import fbpa_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  // Sequencer.
  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .dp_status (dp_status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  // Free lists and address logic.
  fbpa_dp #(
    .SMALL_BLOCK (SMALL_BLOCK),
    .SMALL_COUNT (SMALL_COUNT),
    .MID_BLOCK   (MID_BLOCK),
    .MID_COUNT   (MID_COUNT),
    .LARGE_BLOCK (LARGE_BLOCK),
    .LARGE_COUNT (LARGE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_req_size     (in_req_size),
    .in_release_addr (in_release_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_block_addr  (out_block_addr)
  );

endmodule

`default_nettype wire
